// ----- sv/gwf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gwf_pkg;

    // Fixed field widths of the ports
    localparam int ACT_W      = 2;
    localparam int COORD_W    = 4;
    localparam int HEAD_W     = 2;
    localparam int STAT_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_RESTART = 2'd1,
        ACT_STEP    = 2'd2
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_WRITTEN = 3'd0,
        ST_READY   = 3'd1,
        ST_MOVED   = 3'd2,
        ST_EXITED  = 3'd3,
        ST_BACK    = 3'd4,
        ST_TRAPPED = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_ROW  = 2'd0,
        CFG_START_COL  = 2'd1,
        CFG_START_HEAD = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CHECK,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// ----- sv/gwf_map.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Wall bit map: one write port, one registered read port.
// After reset, sweep every entry to wall, one per cycle, and raise busy.
module gwf_map #(
    parameter int DEPTH = 144,
    parameter int AW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic          i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic               o_rdata,
    output logic               o_busy
);

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic          mem [DEPTH];
    logic          r_busy;
    logic [AW-1:0] r_clr_addr;
    logic          r_rdata;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic          w_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        w_we    = r_busy | i_we;
        w_waddr = r_busy ? r_clr_addr : i_waddr;
        w_wdata = r_busy ? 1'b1 : i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

`default_nettype wire

// ----- sv/grid_wall_follower.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel     Direction  Handshake                  Word
// ---------   ---------  -------------------------  ------------------------------------
// input       in         i_valid / o_ready          i_action, i_row, i_col, i_wall
// result      out        o_valid / i_ready          o_pos_row, o_pos_col, o_heading_out,
//                                                   o_status
// config      in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Load and restart words go from accept to the emit state, which fills the result register.
// A step word passes through a probe for each direction tried, plus a map read in the
// check state for each neighbor inside the grid, then the emit state. The single
// neighbor unit and the one read port of the map make it try directions one at a time.
// After reset the map is swept to all walls while o_ready stays low; config writes
// are taken at all times.
// A stalled result holds in the output register; a new word is taken meanwhile and
// waits in the emit state until the register frees up.
module grid_wall_follower #(
    parameter int GRID_SIZE = 12
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input words
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [gwf_pkg::ACT_W-1:0]      i_action,
    input  wire logic [gwf_pkg::COORD_W-1:0]    i_row,
    input  wire logic [gwf_pkg::COORD_W-1:0]    i_col,
    input  wire logic                           i_wall,
    // result words
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [gwf_pkg::COORD_W-1:0]         o_pos_row,
    output logic [gwf_pkg::COORD_W-1:0]         o_pos_col,
    output logic [gwf_pkg::HEAD_W-1:0]          o_heading_out,
    output logic [gwf_pkg::STAT_W-1:0]          o_status,
    // configuration writes
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [gwf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gwf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Position width: wide enough for the grid and for any start cell.
    localparam int GW    = $clog2(GRID_SIZE);
    localparam int W     = (GW > gwf_pkg::COORD_W) ? GW : gwf_pkg::COORD_W;
    localparam int DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = W + GW + 1;
    localparam logic [W:0]    G_V    = (W + 1)'(GRID_SIZE);
    localparam logic [W-1:0]  G_LAST = W'(GRID_SIZE - 1);
    localparam logic [MW-1:0] G_M    = MW'(GRID_SIZE);

    // Walker state
    gwf_pkg::t_state  r_state, n_state;
    logic [W-1:0]     r_row, n_row;
    logic [W-1:0]     r_col, n_col;
    logic [1:0]       r_head, n_head;
    gwf_pkg::t_status r_final, n_final;
    gwf_pkg::t_status r_res, n_res;
    logic [1:0]       r_k, n_k;
    logic [W-1:0]     r_nb_row, n_nb_row;
    logic [W-1:0]     r_nb_col, n_nb_col;

    // Start configuration
    logic [gwf_pkg::COORD_W-1:0] r_start_row;
    logic [gwf_pkg::COORD_W-1:0] r_start_col;
    logic [gwf_pkg::HEAD_W-1:0]  r_start_head;

    // Output register
    logic                        r_out_valid, n_out_valid;
    logic [gwf_pkg::COORD_W-1:0] r_out_row, n_out_row;
    logic [gwf_pkg::COORD_W-1:0] r_out_col, n_out_col;
    logic [gwf_pkg::HEAD_W-1:0]  r_out_head, n_out_head;
    logic [gwf_pkg::STAT_W-1:0]  r_out_status, n_out_status;

    // Neighbor unit and map port
    logic          w_accept;
    logic [1:0]    w_dir;
    logic          w_vert;
    logic          w_dec;
    logic [W-1:0]  w_opnd;
    logic [W-1:0]  w_other;
    logic [W:0]    w_sum;
    logic          w_inb;
    logic [W-1:0]  w_a_row;
    logic [W-1:0]  w_a_col;
    logic [MW-1:0] w_lin;
    logic [AW-1:0] w_addr;
    logic          w_load_ok;
    logic          w_map_we;
    logic          w_map_re;
    logic          w_map_rdata;
    logic          w_map_busy;
    logic          w_edge;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == gwf_pkg::S_IDLE) && !w_map_busy;
    assign w_accept    = i_valid && o_ready;

    // Shared neighbor unit: one add/subtract on the coordinate that the
    // current direction moves, plus bounds tests.
    always_comb begin
        w_dir   = r_head + r_k;
        w_vert  = ~w_dir[0];   // down and up move the row
        w_dec   = w_dir[1];    // up and left count down
        w_opnd  = w_vert ? r_row : r_col;
        w_other = w_vert ? r_col : r_row;
        w_sum   = {1'b0, w_opnd} + (w_dec ? {(W + 1){1'b1}} : (W + 1)'(1));
        // Zero minus one wraps to all ones, so one compare covers both directions.
        w_inb   = (w_sum < G_V) && ({1'b0, w_other} < G_V);
    end

    // Map address: load cell when idle, neighbor while probing.
    always_comb begin
        if (r_state == gwf_pkg::S_PROBE) begin
            w_a_row = w_vert ? w_sum[W-1:0] : r_row;
            w_a_col = w_vert ? r_col : w_sum[W-1:0];
        end else begin
            w_a_row = W'(i_row);
            w_a_col = W'(i_col);
        end
        w_lin     = MW'(w_a_row) * G_M + MW'(w_a_col);
        w_addr    = w_lin[AW-1:0];
        w_load_ok = ({1'b0, W'(i_row)} < G_V) && ({1'b0, W'(i_col)} < G_V);
        w_map_we  = w_accept && (i_action == gwf_pkg::ACT_LOAD) && w_load_ok;
        w_map_re  = (r_state == gwf_pkg::S_PROBE) && w_inb;
        w_edge    = (r_nb_row == '0) || (r_nb_col == '0) ||
                    (r_nb_row == G_LAST) || (r_nb_col == G_LAST);
    end

    gwf_map #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_map_we),
        .i_waddr (w_addr),
        .i_wdata (i_wall),
        .i_re    (w_map_re),
        .i_raddr (w_addr),
        .o_rdata (w_map_rdata),
        .o_busy  (w_map_busy)
    );

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_col        = r_col;
        n_head       = r_head;
        n_final      = r_final;
        n_res        = r_res;
        n_k          = r_k;
        n_nb_row     = r_nb_row;
        n_nb_col     = r_nb_col;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_row    = r_out_row;
        n_out_col    = r_out_col;
        n_out_head   = r_out_head;
        n_out_status = r_out_status;

        unique case (r_state)
            gwf_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (i_action)
                        gwf_pkg::ACT_LOAD: begin
                            n_res   = gwf_pkg::ST_WRITTEN;
                            n_state = gwf_pkg::S_EMIT;
                        end
                        gwf_pkg::ACT_RESTART: begin
                            n_row   = W'(r_start_row);
                            n_col   = W'(r_start_col);
                            n_head  = r_start_head;
                            n_final = gwf_pkg::ST_READY;
                            n_res   = gwf_pkg::ST_READY;
                            n_state = gwf_pkg::S_EMIT;
                        end
                        default: begin
                            // Step, and the unused code behaves as a step.
                            if (r_final == gwf_pkg::ST_EXITED ||
                                r_final == gwf_pkg::ST_BACK ||
                                r_final == gwf_pkg::ST_TRAPPED) begin
                                n_res   = r_final;
                                n_state = gwf_pkg::S_EMIT;
                            end else begin
                                n_k     = '0;
                                n_state = gwf_pkg::S_PROBE;
                            end
                        end
                    endcase
                end
            end
            gwf_pkg::S_PROBE: begin
                if (w_inb) begin
                    n_nb_row = w_a_row;
                    n_nb_col = w_a_col;
                    n_state  = gwf_pkg::S_CHECK;
                end else if (r_k == 2'd3) begin
                    n_final = gwf_pkg::ST_TRAPPED;
                    n_res   = gwf_pkg::ST_TRAPPED;
                    n_state = gwf_pkg::S_EMIT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            gwf_pkg::S_CHECK: begin
                if (!w_map_rdata) begin
                    // Open cell: move, turn back one notch.
                    n_row  = r_nb_row;
                    n_col  = r_nb_col;
                    n_head = w_dir - 1'b1;
                    if (r_nb_row == W'(r_start_row) && r_nb_col == W'(r_start_col)) begin
                        n_final = gwf_pkg::ST_BACK;
                    end else if (w_edge) begin
                        n_final = gwf_pkg::ST_EXITED;
                    end else begin
                        n_final = gwf_pkg::ST_MOVED;
                    end
                    n_res   = n_final;
                    n_state = gwf_pkg::S_EMIT;
                end else if (r_k == 2'd3) begin
                    n_final = gwf_pkg::ST_TRAPPED;
                    n_res   = gwf_pkg::ST_TRAPPED;
                    n_state = gwf_pkg::S_EMIT;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = gwf_pkg::S_PROBE;
                end
            end
            gwf_pkg::S_EMIT: begin
                // Hold until the output register is free.
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_row    = r_row[gwf_pkg::COORD_W-1:0];
                    n_out_col    = r_col[gwf_pkg::COORD_W-1:0];
                    n_out_head   = r_head;
                    n_out_status = r_res;
                    n_state      = gwf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gwf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gwf_pkg::S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_head      <= 2'd1;
            r_final     <= gwf_pkg::ST_READY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_head      <= n_head;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res        <= n_res;
        r_k          <= n_k;
        r_nb_row     <= n_nb_row;
        r_nb_col     <= n_nb_col;
        r_out_row    <= n_out_row;
        r_out_col    <= n_out_col;
        r_out_head   <= n_out_head;
        r_out_status <= n_out_status;
    end

    // Configuration registers; an index past the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_row  <= '0;
            r_start_col  <= '0;
            r_start_head <= 2'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                gwf_pkg::CFG_START_ROW:  r_start_row  <= i_cfg_data;
                gwf_pkg::CFG_START_COL:  r_start_col  <= i_cfg_data;
                gwf_pkg::CFG_START_HEAD: r_start_head <= i_cfg_data[gwf_pkg::HEAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pos_row     = r_out_row;
    assign o_pos_col     = r_out_col;
    assign o_heading_out = r_out_head;
    assign o_status      = r_out_status;

endmodule

`default_nettype wire

// ----- sim/gwf_walk_monitor.sv -----
`timescale 1ns / 1ps

module gwf_walk_monitor
    import gwf_pkg::*;
#(
    parameter int GRID_SIZE = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [ACT_W-1:0]      i_action,
    input  logic [COORD_W-1:0]    i_row,
    input  logic [COORD_W-1:0]    i_col,
    input  logic                  i_wall,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [COORD_W-1:0]    i_pos_row,
    input  logic [COORD_W-1:0]    i_pos_col,
    input  logic [HEAD_W-1:0]     i_heading,
    input  logic [STAT_W-1:0]     i_status,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int DIR_DOWN  = 0;
    localparam int DIR_RIGHT = 1;
    localparam int DIR_UP    = 2;
    localparam int DIR_LEFT  = 3;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [HEAD_W-1:0]  head;
        logic [STAT_W-1:0]  status;
    } t_walk_word;

    logic               maze_wall [GRID_SIZE][GRID_SIZE];
    logic [COORD_W-1:0] walker_row;
    logic [COORD_W-1:0] walker_col;
    logic [HEAD_W-1:0]  walker_head;
    t_status            walk_state;
    logic [COORD_W-1:0] entry_row;
    logic [COORD_W-1:0] entry_col;
    logic [HEAD_W-1:0]  entry_head;
    t_walk_word         due_words [$];
    int                 mismatches = 0;

    // Cells off the grid count as walls.
    function automatic bit is_open(int r, int c);
        if (r < 0 || c < 0 || r >= GRID_SIZE || c >= GRID_SIZE)
            return 1'b0;
        return !maze_wall[r][c];
    endfunction

    function automatic void walk_one_step();
        int dir;
        int nr;
        int nc;
        bit moved;
        moved = 1'b0;
        // A finished walk stays put until the next restart.
        if (walk_state >= ST_EXITED)
            return;
        for (int k = 0; k < 4 && !moved; k++) begin
            dir = (int'(walker_head) + k) % 4;
            nr  = int'(walker_row);
            nc  = int'(walker_col);
            case (dir)
                DIR_DOWN:  nr = nr + 1;
                DIR_RIGHT: nc = nc + 1;
                DIR_UP:    nr = nr - 1;
                default:   nc = nc - 1;
            endcase
            if (is_open(nr, nc)) begin
                moved       = 1'b1;
                walker_row  = nr[COORD_W-1:0];
                walker_col  = nc[COORD_W-1:0];
                walker_head = HEAD_W'((dir + DIR_LEFT) % 4);
                if (walker_row == entry_row && walker_col == entry_col)
                    walk_state = ST_BACK;
                else if (walker_row == 0 || walker_col == 0 ||
                         walker_row == GRID_SIZE - 1 || walker_col == GRID_SIZE - 1)
                    walk_state = ST_EXITED;
                else
                    walk_state = ST_MOVED;
            end
        end
        if (!moved)
            walk_state = ST_TRAPPED;
    endfunction

    function automatic t_walk_word predict_word(logic [ACT_W-1:0] act,
                                                logic [COORD_W-1:0] r,
                                                logic [COORD_W-1:0] c,
                                                logic w);
        t_walk_word res;
        case (act)
            ACT_LOAD: begin
                if (r < GRID_SIZE && c < GRID_SIZE)
                    maze_wall[r][c] = w;
                res.status = ST_WRITTEN;
            end
            ACT_RESTART: begin
                walker_row  = entry_row;
                walker_col  = entry_col;
                walker_head = entry_head;
                walk_state  = ST_READY;
                res.status  = ST_READY;
            end
            default: begin
                walk_one_step();
                res.status = walk_state;
            end
        endcase
        res.row  = walker_row;
        res.col  = walker_col;
        res.head = walker_head;
        return res;
    endfunction

    function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_walk_word want;
        if (!i_rst_n) begin
            foreach (maze_wall[a, b])
                maze_wall[a][b] = 1'b1;
            walker_row  = '0;
            walker_col  = '0;
            walker_head = HEAD_W'(DIR_RIGHT);
            walk_state  = ST_READY;
            entry_row   = '0;
            entry_col   = '0;
            entry_head  = HEAD_W'(DIR_RIGHT);
            due_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_START_ROW:  entry_row  = i_cfg_data;
                    CFG_START_COL:  entry_col  = i_cfg_data;
                    CFG_START_HEAD: entry_head = i_cfg_data[HEAD_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                due_words.push_back(predict_word(i_action, i_row, i_col, i_wall));
            if (i_res_valid && i_res_ready) begin
                if (due_words.size() == 0) begin
                    $error("result word with nothing outstanding: row %0d col %0d status %0d",
                           i_pos_row, i_pos_col, i_status);
                    mismatches++;
                end else begin
                    want = due_words.pop_front();
                    check_field("pos_row", want.row, i_pos_row);
                    check_field("pos_col", want.col, i_pos_col);
                    check_field("heading_out", 4'(want.head), 4'(i_heading));
                    check_field("status", 4'(want.status), 4'(i_status));
                end
            end
        end
        o_pending    <= due_words.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- sim/grid_wall_follower_tb.sv -----
`timescale 1ns / 1ps

module grid_wall_follower_tb;
    import gwf_pkg::*;

    localparam int GRID         = 12;
    localparam int RANDOM_WORDS = 1850;
    localparam int IDLE_PCT     = 35;
    // Hold the result side closed this long once the random part is well under way.
    localparam int HOLD_AT      = 1200;
    localparam int HOLD_OFF     = 400;
    // Leave room after the slowest step for a stray late word.
    localparam int TAIL_CYCLES  = 24;
    localparam int CYCLE_LIMIT  = 500_000;
    // Action 3 has no name of its own and decodes as a step.
    localparam logic [ACT_W-1:0]     ACT_SPARE = 2'd3;
    // Register index 3 selects nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [ACT_W-1:0]      in_action = ACT_LOAD;
    logic [COORD_W-1:0]    in_row    = '0;
    logic [COORD_W-1:0]    in_col    = '0;
    logic                  in_wall   = 1'b0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    logic [COORD_W-1:0]    pos_row;
    logic [COORD_W-1:0]    pos_col;
    logic [HEAD_W-1:0]     heading;
    logic [STAT_W-1:0]     status;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_START_ROW;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int cycles     = 0;
    int words_sent = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    // While set, neither side inserts idle cycles.
    bit steady     = 1'b0;

    always #5 clk = ~clk;

    grid_wall_follower #(
        .GRID_SIZE(GRID)
    ) uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_action     (in_action),
        .i_row        (in_row),
        .i_col        (in_col),
        .i_wall       (in_wall),
        .o_valid      (res_valid),
        .i_ready      (res_ready),
        .o_pos_row    (pos_row),
        .o_pos_col    (pos_col),
        .o_heading_out(heading),
        .o_status     (status),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    gwf_walk_monitor #(
        .GRID_SIZE(GRID)
    ) monitor (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_action    (in_action),
        .i_row       (in_row),
        .i_col       (in_col),
        .i_wall      (in_wall),
        .i_res_valid (res_valid),
        .i_res_ready (res_ready),
        .i_pos_row   (pos_row),
        .i_pos_col   (pos_col),
        .i_heading   (heading),
        .i_status    (status),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Abort a run that hangs.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random back-pressure, one long hold-off counted here, none while steady.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            res_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && words_sent >= HOLD_AT) begin
            res_ready <= 1'b0;
            hold_left <= HOLD_OFF;
            hold_done <= 1'b1;
        end else begin
            res_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offer one input word after a random gap; hold it until taken.
    // Valid is lowered here only when a gap is taken, so back-to-back words keep it high.
    task automatic send_word(input logic [ACT_W-1:0] act, input logic [COORD_W-1:0] r,
                             input logic [COORD_W-1:0] c, input logic w);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_row    <= r;
        in_col    <= c;
        in_wall   <= w;
        do begin
            @(posedge clk);
        end while (!in_ready);
        words_sent++;
    endtask

    // Drop valid and wait for every outstanding result word.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
    endtask

    task automatic set_start(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                             input logic [HEAD_W-1:0] h);
        write_reg(CFG_START_ROW, r);
        write_reg(CFG_START_COL, c);
        write_reg(CFG_START_HEAD, CFG_DATA_W'(h));
        cfg_valid <= 1'b0;
    endtask

    // Mostly in-grid cells, a few beyond the edge that must write nothing.
    function automatic logic [COORD_W-1:0] cell_coord();
        if ($urandom_range(99) < 8)
            return COORD_W'($urandom_range(15, GRID));
        return COORD_W'($urandom_range(GRID - 1));
    endfunction

    // Start cells lean on the corners and edges, with some off the grid.
    function automatic logic [COORD_W-1:0] start_coord();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return '0;
        if (roll < 30)
            return COORD_W'(GRID - 1);
        if (roll < 38)
            return COORD_W'($urandom_range(15, GRID));
        return COORD_W'($urandom_range(GRID - 1));
    endfunction

    initial begin : stimulus
        int n_loads;
        int n_steps;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // All walls after reset: the walker is boxed in, and stays boxed in.
        send_word(ACT_STEP, '0, '0, 1'b0);
        send_word(ACT_SPARE, 4'hF, 4'hF, 1'b1);
        // Loads past the grid edge change nothing but still answer.
        send_word(ACT_LOAD, 4'd12, 4'd3, 1'b0);
        send_word(ACT_LOAD, 4'hF, 4'hF, 1'b1);
        send_word(ACT_LOAD, 4'd3, 4'hF, 1'b0);
        send_word(ACT_LOAD, 4'd11, 4'd11, 1'b0);
        send_word(ACT_LOAD, 4'd0, 4'd1, 1'b0);
        // From the corner the first move lands on the edge: exit, then repeat it.
        send_word(ACT_RESTART, '0, '0, 1'b0);
        send_word(ACT_STEP, '0, '0, 1'b0);
        send_word(ACT_STEP, 4'hA, 4'h5, 1'b1);

        // Interior start: one move out, one back to the start cell.
        wait_idle();
        write_reg(CFG_SPARE, 4'hF);
        set_start(4'd5, 4'd5, HEAD_W'(1));
        send_word(ACT_LOAD, 4'd5, 4'd5, 1'b0);
        send_word(ACT_LOAD, 4'd5, 4'd6, 1'b0);
        send_word(ACT_RESTART, '0, '0, 1'b0);
        send_word(ACT_STEP, '0, '0, 1'b0);
        send_word(ACT_STEP, '0, '0, 1'b0);
        send_word(ACT_SPARE, '0, '0, 1'b0);

        // Start off the grid with nothing in reach.
        wait_idle();
        set_start(4'hF, 4'hF, HEAD_W'(3));
        send_word(ACT_RESTART, '0, '0, 1'b0);
        send_word(ACT_STEP, '0, '0, 1'b0);

        // Start just below the grid: step up onto the bottom edge.
        wait_idle();
        set_start(4'd12, 4'd4, HEAD_W'(2));
        send_word(ACT_LOAD, 4'd11, 4'd4, 1'b0);
        send_word(ACT_RESTART, '0, '0, 1'b0);
        send_word(ACT_STEP, '0, '0, 1'b0);

        wait_idle();
        set_start(4'd0, 4'd11, HEAD_W'(0));
        send_word(ACT_RESTART, '0, '0, 1'b0);
        send_word(ACT_STEP, '0, '0, 1'b0);

        // Random walks: carve some cells, maybe move the start, restart, then step blind.
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            steady = (words_sent >= 600 && words_sent < 900);
            if ($urandom_range(2) == 0) begin
                wait_idle();
                set_start(start_coord(), start_coord(), HEAD_W'($urandom_range(3)));
            end
            n_loads = $urandom_range(40, 4);
            repeat (n_loads)
                send_word(ACT_LOAD, cell_coord(), cell_coord(), $urandom_range(99) < 35);
            send_word(ACT_RESTART, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
            n_steps = $urandom_range(60, 3);
            repeat (n_steps) begin
                // Now and then drop in a word of any kind mid-walk.
                if ($urandom_range(99) < 8)
                    send_word(ACT_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                              1'($urandom));
                else if ($urandom_range(9) == 0)
                    send_word(ACT_SPARE, COORD_W'($urandom), COORD_W'($urandom),
                              1'($urandom));
                else
                    send_word(ACT_STEP, COORD_W'($urandom), COORD_W'($urandom),
                              1'($urandom));
            end
        end
        steady = 1'b0;

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/gwf_pkg.sv
sv/gwf_map.sv
sv/grid_wall_follower.sv
sim/gwf_walk_monitor.sv
sim/grid_wall_follower_tb.sv
